// File: src/pursuit_pi_velocity_controller_assert.svh
// Assertion macros for the pursuit PI velocity controller
`ifndef PURSUIT_PI_VELOCITY_CONTROLLER_ASSERT_SVH
`define PURSUIT_PI_VELOCITY_CONTROLLER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define PPVC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppvc check failed");

// Next-cycle implication.
`define PPVC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppvc check failed");

`endif

// File: src/ppvc_pkg.sv
// Shared types, constants and functions of the pursuit PI velocity controller
package ppvc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int XW = 36;
    localparam int ZW = 21;
    localparam int CNTW = $clog2(CORDIC_STEPS + 1);

    localparam logic signed [ZW-1:0] ANG_PI = 21'sd205887;
    localparam logic signed [23:0] ANG_PI_W = 24'sd205887;
    localparam logic signed [23:0] ANG_2PI_W = 24'sd411775;
    localparam logic [31:0] INV_GAIN = 32'd2608131496;
    localparam logic [15:0] RECIP5 = 16'd52429;

    localparam logic [3:0] REG_TRACKING_DISTANCE = 4'd0;
    localparam logic [3:0] REG_ANGLE_TOLERANCE = 4'd1;
    localparam logic [3:0] REG_MAX_LINEAR_SPEED = 4'd2;
    localparam logic [3:0] REG_MAX_ANGULAR_SPEED = 4'd3;
    localparam logic [3:0] REG_LINEAR_P_GAIN = 4'd4;
    localparam logic [3:0] REG_LINEAR_I_GAIN = 4'd5;
    localparam logic [3:0] REG_ANGULAR_P_GAIN = 4'd6;
    localparam logic [3:0] REG_ANGULAR_I_GAIN = 4'd7;

    typedef enum logic [1:0] {
        MODE_ROTATE = 2'd0,
        MODE_TRANSLATE = 2'd1,
        MODE_BOTH = 2'd2
    } drive_mode_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    // atan(2^-i) in units of 2^-16 rad, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_lookup(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        begin
            case (idx)
                5'd0: v = 21'sd51472;
                5'd1: v = 21'sd30385;
                5'd2: v = 21'sd16055;
                5'd3: v = 21'sd8150;
                5'd4: v = 21'sd4091;
                5'd5: v = 21'sd2047;
                5'd6: v = 21'sd1024;
                5'd7: v = 21'sd512;
                5'd8: v = 21'sd256;
                5'd9: v = 21'sd128;
                5'd10: v = 21'sd64;
                5'd11: v = 21'sd32;
                5'd12: v = 21'sd16;
                5'd13: v = 21'sd8;
                5'd14: v = 21'sd4;
                5'd15: v = 21'sd2;
                5'd16: v = 21'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        begin
            if (v > 42'sd2147483647)
                r = 32'sh7FFFFFFF;
            else if (v < -42'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

// File: src/ppvc_cordic_cell.sv
// One vectoring CORDIC rotation cell with a registered output
module ppvc_cordic_cell (
    input  logic              clk,
    input  logic [4:0]        shift,
    input  ppvc_pkg::cordic_t prev,
    output ppvc_pkg::cordic_t curr_reg
);

    ppvc_pkg::cordic_t curr_next;
    logic signed [ppvc_pkg::XW-1:0] xs;
    logic signed [ppvc_pkg::XW-1:0] ys;
    logic signed [ppvc_pkg::ZW-1:0] ang;

    assign xs = prev.x >>> shift;
    assign ys = prev.y >>> shift;
    assign ang = ppvc_pkg::atan_lookup(shift);

    // rotate toward the x axis
    always_comb
    begin
        if (!prev.y[ppvc_pkg::XW-1])
        begin
            curr_next.x = prev.x + ys;
            curr_next.y = prev.y - xs;
            curr_next.z = prev.z + ang;
        end
        else
        begin
            curr_next.x = prev.x - ys;
            curr_next.y = prev.y + xs;
            curr_next.z = prev.z - ang;
        end
    end

    always_ff @(posedge clk)
    begin
        curr_reg <= curr_next;
    end

endmodule

// File: src/pursuit_pi_velocity_controller.sv
// Top level of the pursuit PI velocity controller
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  in      | in_valid / in_ready    | robot_x, robot_y, robot_heading, target_x/y
//  out     | out_valid / out_ready  | linear_command, angular_command, drive_mode
//  cfg     | cfg_write (no wait)    | cfg_index, cfg_data
//
// The result of a transaction passes through the chain of CORDIC cells and then the
// shared 20x17 multiplier, which runs six products in turn; once the result is in the
// output register the sequencer returns to idle and the next input can be taken.
// One transaction is worked at a time; in_ready rises again as soon as the result
// sits in the output register, even if out_ready is low. A stalled output holds the
// sequencer in its final step. Reset sets the configuration registers to their
// defaults and clears both integrators.
`include "pursuit_pi_velocity_controller_assert.svh"

module pursuit_pi_velocity_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] robot_x,
    input  logic signed [31:0] robot_y,
    input  logic signed [15:0] robot_heading,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] linear_command,
    output logic signed [31:0] angular_command,
    output logic [1:0]         drive_mode,
    input  logic               cfg_write,
    input  logic [3:0]         cfg_index,
    input  logic [30:0]        cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_CORD, S_RNG1, S_RNG2, S_MODE,
        S_AI, S_AP, S_LI_LO, S_LI_HI, S_LP_LO, S_LP_HI,
        S_INT, S_SUM, S_CMD
    } state_t;

    localparam int N = ppvc_pkg::CORDIC_STEPS;
    localparam int XW = ppvc_pkg::XW;
    localparam int ZW = ppvc_pkg::ZW;

    state_t state_reg;
    logic [ppvc_pkg::CNTW-1:0] cnt_reg;

    // configuration
    logic [30:0] tracking_distance_reg;
    logic [14:0] angle_tolerance_reg;
    logic [30:0] max_linear_speed_reg;
    logic [30:0] max_angular_speed_reg;
    logic [15:0] linear_p_gain_reg;
    logic [15:0] linear_i_gain_reg;
    logic [15:0] angular_p_gain_reg;
    logic [15:0] angular_i_gain_reg;

    // integrators
    logic signed [31:0] linear_integral_reg;
    logic signed [31:0] angular_integral_reg;

    // datapath registers
    logic signed [32:0] dx_reg;
    logic signed [32:0] dy_reg;
    logic signed [15:0] heading_reg;
    logic               zero_reg;
    ppvc_pkg::cordic_t  seed_reg;
    logic [50:0]        phi_reg;
    logic [47:0]        plo_reg;
    logic signed [15:0] err_a_reg;
    logic [14:0]        abs_a_reg;
    logic signed [35:0] err_l_reg;
    logic [12:0]        tol5_reg;
    ppvc_pkg::drive_mode_t mode_reg;
    logic signed [36:0] ai_reg;
    logic signed [36:0] ap_reg;
    logic signed [52:0] li_reg;
    logic signed [52:0] lp_reg;
    logic signed [27:0] ap_sh_reg;
    logic signed [40:0] lp_sh_reg;
    logic signed [42:0] ang_sum_reg;
    logic signed [42:0] lin_sum_reg;

    logic               out_valid_reg;
    logic signed [31:0] linear_command_reg;
    logic signed [31:0] angular_command_reg;
    ppvc_pkg::drive_mode_t drive_mode_reg;

    ppvc_pkg::cordic_t chain [0:N];

    assign chain[0] = seed_reg;

    // chain of CORDIC cells; each advances the vector by one rotation per cycle
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        ppvc_cordic_cell u_cell (
            .clk      (clk),
            .shift    (5'(i)),
            .prev     (chain[i]),
            .curr_reg (chain[i+1])
        );
    end

    // bearing and angle error from the last cell
    logic signed [XW-1:0] xf;
    logic [34:0]          ux;
    logic signed [23:0]   bear;
    logic signed [23:0]   e0;
    logic signed [23:0]   e1;
    logic signed [23:0]   e2;
    logic signed [23:0]   e3;
    logic signed [23:0]   e4;
    logic signed [20:0]   err_a_wide;
    logic signed [15:0]   err_a;

    function automatic logic signed [23:0] wrap_step(input logic signed [23:0] v);
        logic signed [23:0] r;
        begin
            if (v > ppvc_pkg::ANG_PI_W)
                r = v - ppvc_pkg::ANG_2PI_W;
            else if (v < -ppvc_pkg::ANG_PI_W)
                r = v + ppvc_pkg::ANG_2PI_W;
            else
                r = v;
            return r;
        end
    endfunction

    always_comb
    begin
        xf = zero_reg ? '0 : chain[N].x;
        ux = xf[34:0];
        bear = zero_reg ? '0 : 24'(chain[N].z);
        if (bear < 0)
            bear = bear + ppvc_pkg::ANG_2PI_W;
        e0 = bear - {{5{heading_reg[15]}}, heading_reg, 3'b000};
        e1 = wrap_step(e0);
        e2 = wrap_step(e1);
        e3 = wrap_step(e2);
        e4 = e3 + 24'sd4;
        err_a_wide = e4[23:3];
        err_a = err_a_wide[15:0];
    end

    // range, distance error and the tolerance divided by five
    logic [51:0]  range_sum;
    logic [30:0]  tol_prod;
    assign range_sum = 52'(phi_reg) + 52'(plo_reg[47:16]);
    assign tol_prod = angle_tolerance_reg * ppvc_pkg::RECIP5;

    // shared multiplier: one product a step
    logic signed [19:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [36:0] mul_p;
    logic signed [19:0] err_l_hi;
    logic signed [19:0] err_l_lo;

    assign err_l_hi = err_l_reg[35:16];
    assign err_l_lo = {4'b0000, err_l_reg[15:0]};

    always_comb
    begin
        case (state_reg)
            S_AI:
            begin
                mul_a = 20'(err_a_reg);
                mul_b = {1'b0, angular_i_gain_reg};
            end
            S_AP:
            begin
                mul_a = 20'(err_a_reg);
                mul_b = {1'b0, angular_p_gain_reg};
            end
            S_LI_LO:
            begin
                mul_a = err_l_lo;
                mul_b = {1'b0, linear_i_gain_reg};
            end
            S_LI_HI:
            begin
                mul_a = err_l_hi;
                mul_b = {1'b0, linear_i_gain_reg};
            end
            S_LP_LO:
            begin
                mul_a = err_l_lo;
                mul_b = {1'b0, linear_p_gain_reg};
            end
            S_LP_HI:
            begin
                mul_a = err_l_hi;
                mul_b = {1'b0, linear_p_gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // integrator update and clamp
    logic               ang_active;
    logic               lin_active;
    logic signed [41:0] ang_int_sum;
    logic signed [41:0] lin_int_sum;
    logic signed [42:0] ang_lim;
    logic signed [42:0] lin_lim;
    logic signed [42:0] ang_clamped;
    logic signed [42:0] lin_clamped;

    assign ang_active = (mode_reg != ppvc_pkg::MODE_TRANSLATE);
    assign lin_active = (mode_reg != ppvc_pkg::MODE_ROTATE);
    assign ang_int_sum = 42'(angular_integral_reg) + 42'($signed(ai_reg[36:9]));
    assign lin_int_sum = 42'(linear_integral_reg) + 42'($signed(li_reg[52:12]));
    assign ang_lim = $signed({12'b0, max_angular_speed_reg});
    assign lin_lim = $signed({12'b0, max_linear_speed_reg});

    always_comb
    begin
        if (ang_sum_reg > ang_lim)
            ang_clamped = ang_lim;
        else if (ang_sum_reg < -ang_lim)
            ang_clamped = -ang_lim;
        else
            ang_clamped = ang_sum_reg;
        if (lin_sum_reg > lin_lim)
            lin_clamped = lin_lim;
        else if (lin_sum_reg < -lin_lim)
            lin_clamped = -lin_lim;
        else
            lin_clamped = lin_sum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            tracking_distance_reg <= '0;
            angle_tolerance_reg <= 15'd4096;
            max_linear_speed_reg <= 31'd65536;
            max_angular_speed_reg <= 31'd65536;
            linear_p_gain_reg <= 16'd4096;
            linear_i_gain_reg <= 16'd410;
            angular_p_gain_reg <= 16'd4915;
            angular_i_gain_reg <= 16'd410;
            linear_integral_reg <= '0;
            angular_integral_reg <= '0;
            dx_reg <= '0;
            dy_reg <= '0;
            heading_reg <= '0;
            zero_reg <= 1'b0;
            seed_reg <= '0;
            phi_reg <= '0;
            plo_reg <= '0;
            err_a_reg <= '0;
            abs_a_reg <= '0;
            err_l_reg <= '0;
            tol5_reg <= '0;
            mode_reg <= ppvc_pkg::MODE_ROTATE;
            ai_reg <= '0;
            ap_reg <= '0;
            li_reg <= '0;
            lp_reg <= '0;
            ap_sh_reg <= '0;
            lp_sh_reg <= '0;
            ang_sum_reg <= '0;
            lin_sum_reg <= '0;
            out_valid_reg <= 1'b0;
            linear_command_reg <= '0;
            angular_command_reg <= '0;
            drive_mode_reg <= ppvc_pkg::MODE_ROTATE;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    ppvc_pkg::REG_TRACKING_DISTANCE: tracking_distance_reg <= cfg_data;
                    ppvc_pkg::REG_ANGLE_TOLERANCE: angle_tolerance_reg <= cfg_data[14:0];
                    ppvc_pkg::REG_MAX_LINEAR_SPEED: max_linear_speed_reg <= cfg_data;
                    ppvc_pkg::REG_MAX_ANGULAR_SPEED: max_angular_speed_reg <= cfg_data;
                    ppvc_pkg::REG_LINEAR_P_GAIN: linear_p_gain_reg <= cfg_data[15:0];
                    ppvc_pkg::REG_LINEAR_I_GAIN: linear_i_gain_reg <= cfg_data[15:0];
                    ppvc_pkg::REG_ANGULAR_P_GAIN: angular_p_gain_reg <= cfg_data[15:0];
                    ppvc_pkg::REG_ANGULAR_I_GAIN: angular_i_gain_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end

            // drop the result once the consumer takes it, unless a new one replaces it
            if (out_valid_reg && out_ready && state_reg != S_CMD)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        dx_reg <= 33'(target_x) - 33'(robot_x);
                        dy_reg <= 33'(target_y) - 33'(robot_y);
                        heading_reg <= robot_heading;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    // fold the left half plane onto the right one
                    zero_reg <= (dx_reg == '0) && (dy_reg == '0);
                    if (dx_reg < 0)
                    begin
                        seed_reg.x <= -XW'(dx_reg);
                        seed_reg.y <= -XW'(dy_reg);
                        seed_reg.z <= (dy_reg < 0) ? -ppvc_pkg::ANG_PI : ppvc_pkg::ANG_PI;
                    end
                    else
                    begin
                        seed_reg.x <= XW'(dx_reg);
                        seed_reg.y <= XW'(dy_reg);
                        seed_reg.z <= '0;
                    end
                    cnt_reg <= '0;
                    state_reg <= S_CORD;
                end
                S_CORD:
                begin
                    // wait for the vector to pass every cell
                    if (cnt_reg == ppvc_pkg::CNTW'(N - 1))
                        state_reg <= S_RNG1;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_RNG1:
                begin
                    phi_reg <= ux[34:16] * ppvc_pkg::INV_GAIN;
                    plo_reg <= ux[15:0] * ppvc_pkg::INV_GAIN;
                    err_a_reg <= err_a;
                    abs_a_reg <= err_a[15] ? 15'(-err_a) : err_a[14:0];
                    state_reg <= S_RNG2;
                end
                S_RNG2:
                begin
                    err_l_reg <= $signed({1'b0, range_sum[50:16]})
                        - $signed({5'b0, tracking_distance_reg});
                    tol5_reg <= tol_prod[30:18];
                    state_reg <= S_MODE;
                end
                S_MODE:
                begin
                    if (abs_a_reg > angle_tolerance_reg)
                        mode_reg <= ppvc_pkg::MODE_ROTATE;
                    else if (abs_a_reg > 15'(tol5_reg))
                        mode_reg <= ppvc_pkg::MODE_TRANSLATE;
                    else
                        mode_reg <= ppvc_pkg::MODE_BOTH;
                    state_reg <= S_AI;
                end
                S_AI:
                begin
                    ai_reg <= mul_p;
                    state_reg <= S_AP;
                end
                S_AP:
                begin
                    ap_reg <= mul_p;
                    state_reg <= S_LI_LO;
                end
                S_LI_LO:
                begin
                    li_reg <= 53'(mul_p);
                    state_reg <= S_LI_HI;
                end
                S_LI_HI:
                begin
                    li_reg <= li_reg + (53'(mul_p) <<< 16);
                    state_reg <= S_LP_LO;
                end
                S_LP_LO:
                begin
                    lp_reg <= 53'(mul_p);
                    state_reg <= S_LP_HI;
                end
                S_LP_HI:
                begin
                    lp_reg <= lp_reg + (53'(mul_p) <<< 16);
                    state_reg <= S_INT;
                end
                S_INT:
                begin
                    // integrators advance only on an active axis
                    if (ang_active)
                        angular_integral_reg <= ppvc_pkg::sat32(ang_int_sum);
                    if (lin_active)
                        linear_integral_reg <= ppvc_pkg::sat32(lin_int_sum);
                    ap_sh_reg <= $signed(ap_reg[36:9]);
                    lp_sh_reg <= $signed(lp_reg[52:12]);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    ang_sum_reg <= 43'(ap_sh_reg) + 43'(angular_integral_reg);
                    lin_sum_reg <= 43'(lp_sh_reg) + 43'(linear_integral_reg);
                    state_reg <= S_CMD;
                end
                S_CMD:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        angular_command_reg <= ang_active ? ang_clamped[31:0] : '0;
                        linear_command_reg <= lin_active ? lin_clamped[31:0] : '0;
                        drive_mode_reg <= mode_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign linear_command = linear_command_reg;
    assign angular_command = angular_command_reg;
    assign drive_mode = drive_mode_reg;

    `PPVC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
    `PPVC_ASSERT_NOW(a_mode_legal, out_valid, drive_mode != 2'd3)
    `PPVC_ASSERT_NOW(a_rotate_no_linear,
        out_valid && drive_mode == ppvc_pkg::MODE_ROTATE, linear_command == '0)
    `PPVC_ASSERT_NOW(a_translate_no_angular,
        out_valid && drive_mode == ppvc_pkg::MODE_TRANSLATE, angular_command == '0)

endmodule
